// File: rtl/twhhd_pkg.sv
// Shared types and constants for the three-wheel heading-hold drive.
// Field widths, configuration register indexes, sector codes and PID sizing.
// No dependencies.
package twhhd_pkg;

    // Field widths
    localparam int DIR_W    = 13;   // travel direction, signed tenths of a degree
    localparam int SPD_W    = 8;    // speeds
    localparam int HDG_W    = 16;   // gyro heading / robot angle
    localparam int ERR_W    = HDG_W + 1;  // heading error
    localparam int DRV_W    = ERR_W + 1;  // error difference
    localparam int INTEG_W  = 32;   // saturating integral
    localparam int GAIN_W   = 12;   // Q4.8 gains
    localparam int LIM_W    = 10;   // correction limit
    localparam int STEER_W  = 18;   // steer angles
    localparam int NORM_W   = 12;   // direction folded into 0..3599
    localparam int CORR_W   = LIM_W + 1;
    localparam int WHEEL_W  = 12;   // speed plus or minus correction

    localparam int GAIN_FRACTION_BITS = 8;

    // Product and sum widths
    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + INTEG_W;
    localparam int D_W   = GAIN_W + 1 + DRV_W;
    localparam int SUM_W = I_W + 2;

    // Stream packing
    localparam int S_TDATA_W = 40;  // 37 payload bits rounded to bytes
    localparam int M_TDATA_W = 80;  // 78 payload bits rounded to bytes

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_CORR_LIM  = 3'd3,
        CFG_SPEED_MAX = 3'd4,
        CFG_SPEED_MIN = 3'd5
    } cfg_index_t;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST    = 12'd154;
    localparam logic [GAIN_W-1:0] GAIN_I_RST    = 12'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST    = 12'd102;
    localparam logic [LIM_W-1:0]  CORR_LIM_RST  = 10'd250;
    localparam logic [SPD_W-1:0]  SPEED_MAX_RST = 8'd254;
    localparam logic [SPD_W-1:0]  SPEED_MIN_RST = 8'd3;

    // Direction sectors
    typedef enum logic [1:0] {
        SEC_AHEAD = 2'd0,   // above 3150 or at most 450
        SEC_RIGHT = 2'd1,   // at most 1350
        SEC_BACK  = 2'd2,   // at most 2250
        SEC_LEFT  = 2'd3    // the rest
    } sector_t;

    localparam int DIR_FULL      = 3600;
    localparam int SEC_AHEAD_LO  = 3150;
    localparam int SEC_AHEAD_HI  = 450;
    localparam int SEC_RIGHT_HI  = 1350;
    localparam int SEC_BACK_HI   = 2250;
    localparam int STEER_OFFSET  = 1200;

    // Ramp
    localparam logic [SPD_W-1:0] RAMP_FAST_FROM = 8'd50;
    localparam logic [SPD_W-1:0] RAMP_STEP_SLOW = 8'd1;
    localparam logic [SPD_W-1:0] RAMP_STEP_FAST = 8'd3;

endpackage

// File: rtl/three_wheel_heading_hold_drive.sv
// Top level of the three-wheel heading-hold drive: speed ramp, heading PID,
// sector mixing, wheel clamps and steer angles in a four-stage pipeline.
// Depends on twhhd_pkg.

// One request per control tick gives one result: three wheel speeds and three
// steer angles. The block takes a request every clock cycle while the result
// side keeps up; a request moves through stages A, B, C to the output register.
// Ramp, reference heading, integral and last error are all updated in the
// first stage, so consecutive requests see each other's state with no gap.
// The stages after it hold the three gain products, the clamped correction
// and the output register; all stages stall together when a result waits. The
// user writes configuration (cfg_ port) with no request in flight; unchecked.
module three_wheel_heading_hold_drive (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: travel_direction[12:0], speed_setpoint[20:13], gyro_heading[36:21]
    input  logic [twhhd_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: restart_hold
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: speed_wheel_front[7:0], speed_wheel_right[15:8],
    //          speed_wheel_left[23:16], steer_front[41:24],
    //          steer_right[59:42], steer_left[77:60]
    output logic [twhhd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [twhhd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twhhd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import twhhd_pkg::*;

    // x mod 3 == 0 by summing base-4 digits
    function automatic logic mod3_zero(input logic [SPD_W-1:0] x);
        logic [3:0] s1;
        logic [2:0] s2;
        s1 = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
        return (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
    endfunction

    // wheel clamp, max wins when the bounds cross
    function automatic logic [SPD_W-1:0] clamp_wheel(
        input logic signed [WHEEL_W-1:0] v,
        input logic [SPD_W-1:0]          mx,
        input logic [SPD_W-1:0]          mn
    );
        logic [SPD_W-1:0] r;
        if (v >= $signed({{(WHEEL_W-SPD_W){1'b0}}, mx})) begin
            r = mx;
        end else if (v <= $signed({{(WHEEL_W-SPD_W){1'b0}}, mn})) begin
            r = mn;
        end else begin
            r = v[SPD_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIM_W-1:0]  corr_lim_reg;
    logic [SPD_W-1:0]  speed_max_reg, speed_min_reg;

    // Control-loop state
    logic [SPD_W-1:0]          ramp_speed_reg, ramp_speed_next;
    logic [SPD_W-1:0]          ramp_cnt_reg, ramp_cnt_next;
    logic signed [HDG_W-1:0]   ref_hdg_reg, ref_hdg_next;
    logic                      ref_stale_reg;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   last_err_reg;

    // Pipeline valids
    logic a_valid_reg, b_valid_reg, c_valid_reg, out_valid_reg;
    logic adv, s_accept;

    // Stage A payload
    logic [SPD_W-1:0]          a_speed_reg;
    logic signed [ERR_W-1:0]   a_err_reg;
    logic signed [INTEG_W-1:0] a_integ_reg;
    logic signed [DRV_W-1:0]   a_drv_reg;
    logic signed [DIR_W-1:0]   a_dir_reg;
    sector_t                   a_sec_reg;

    // Stage B payload
    logic signed [P_W-1:0]     b_prod_p_reg;
    logic signed [I_W-1:0]     b_prod_i_reg;
    logic signed [D_W-1:0]     b_prod_d_reg;
    logic [SPD_W-1:0]          b_speed_reg;
    logic signed [ERR_W-1:0]   b_err_reg;
    logic signed [DIR_W-1:0]   b_dir_reg;
    sector_t                   b_sec_reg;

    // Stage C payload
    logic signed [CORR_W-1:0]  c_corr_reg, c_corr_next;
    logic [SPD_W-1:0]          c_speed_reg;
    logic signed [ERR_W-1:0]   c_err_reg;
    logic signed [DIR_W-1:0]   c_dir_reg;
    sector_t                   c_sec_reg;

    // Output register
    logic [M_TDATA_W-1:0]      out_data_reg, out_data_next;

    // Input unpacking
    logic signed [DIR_W-1:0]   in_dir;
    logic [SPD_W-1:0]          in_target;
    logic signed [HDG_W-1:0]   in_gyro;
    logic signed [HDG_W-1:0]   in_angle;

    assign in_dir    = $signed(s_tdata[DIR_W-1:0]);
    assign in_target = s_tdata[DIR_W+SPD_W-1:DIR_W];
    assign in_gyro   = $signed(s_tdata[DIR_W+SPD_W+HDG_W-1:DIR_W+SPD_W]);
    assign in_angle  = -in_gyro;

    // Whole pipeline moves when the output slot is free or being taken
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            corr_lim_reg  <= CORR_LIM_RST;
            speed_max_reg <= SPEED_MAX_RST;
            speed_min_reg <= SPEED_MIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN_P:    gain_p_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:    gain_i_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:    gain_d_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_CORR_LIM:  corr_lim_reg  <= cfg_wdata[LIM_W-1:0];
                CFG_SPEED_MAX: speed_max_reg <= cfg_wdata[SPD_W-1:0];
                CFG_SPEED_MIN: speed_min_reg <= cfg_wdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- Stage A: state update ----------------
    logic                      ramp_up, ramp_dn;
    logic [SPD_W:0]            ramp_inc;
    logic [SPD_W-1:0]          ramp_up_val, ramp_dn_val;
    logic signed [ERR_W-1:0]   err_now;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [DRV_W-1:0]   drv_now;
    logic signed [DIR_W:0]     dir_wide;
    logic [NORM_W-1:0]         dir_norm;
    sector_t                   sec_now;

    // Speed ramp
    always_comb begin
        ramp_up  = ramp_speed_reg < in_target;
        ramp_dn  = ramp_speed_reg > in_target;
        ramp_inc = {1'b0, ramp_speed_reg} +
                   {1'b0, (ramp_speed_reg < RAMP_FAST_FROM) ? RAMP_STEP_SLOW : RAMP_STEP_FAST};
        ramp_up_val = (ramp_inc >= {1'b0, in_target}) ? in_target : ramp_inc[SPD_W-1:0];
        ramp_dn_val = ({1'b0, ramp_speed_reg} <= ({1'b0, in_target} + {1'b0, RAMP_STEP_FAST}))
                      ? in_target : ramp_speed_reg - RAMP_STEP_FAST;
        ramp_speed_next = ramp_speed_reg;
        ramp_cnt_next   = ramp_cnt_reg;
        if (ramp_up) begin
            ramp_cnt_next = ramp_cnt_reg + 8'd1;
            if (mod3_zero(ramp_cnt_reg)) begin
                ramp_speed_next = ramp_up_val;
            end
        end else if (ramp_dn) begin
            ramp_cnt_next = ramp_cnt_reg + 8'd1;
            if (!ramp_cnt_reg[0]) begin
                ramp_speed_next = ramp_dn_val;
            end
        end
    end

    // Reference latch, error, saturating integral, difference
    always_comb begin
        ref_hdg_next = (s_tuser || ref_stale_reg) ? in_angle : ref_hdg_reg;
        err_now   = ERR_W'(ref_hdg_next) - ERR_W'(in_angle);
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_now);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
        drv_now = DRV_W'(err_now) - DRV_W'(last_err_reg);
    end

    // Direction folded into one turn, then sector
    always_comb begin
        dir_wide = (DIR_W+1)'(in_dir);
        if (dir_wide < -(DIR_W+1)'(DIR_FULL)) begin
            dir_wide = dir_wide + (DIR_W+1)'(2 * DIR_FULL);
        end else if (dir_wide < 0) begin
            dir_wide = dir_wide + (DIR_W+1)'(DIR_FULL);
        end else if (dir_wide >= (DIR_W+1)'(DIR_FULL)) begin
            dir_wide = dir_wide - (DIR_W+1)'(DIR_FULL);
        end
        dir_norm = dir_wide[NORM_W-1:0];
        priority if (dir_norm > NORM_W'(SEC_AHEAD_LO) || dir_norm <= NORM_W'(SEC_AHEAD_HI)) begin
            sec_now = SEC_AHEAD;
        end else if (dir_norm <= NORM_W'(SEC_RIGHT_HI)) begin
            sec_now = SEC_RIGHT;
        end else if (dir_norm <= NORM_W'(SEC_BACK_HI)) begin
            sec_now = SEC_BACK;
        end else begin
            sec_now = SEC_LEFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_speed_reg <= '0;
            ramp_cnt_reg   <= '0;
            ref_hdg_reg    <= '0;
            ref_stale_reg  <= 1'b1;
            integ_reg      <= '0;
            last_err_reg   <= '0;
        end else if (s_accept) begin
            ramp_speed_reg <= ramp_speed_next;
            ramp_cnt_reg   <= ramp_cnt_next;
            ref_hdg_reg    <= ref_hdg_next;
            ref_stale_reg  <= 1'b0;
            integ_reg      <= integ_next;
            last_err_reg   <= err_now;
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= s_tvalid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    // ---------------- Pipeline payload ----------------
    logic signed [SUM_W-1:0]   pid_sum, pid_trunc, lim_pos;

    // Stage C: sum, truncate toward zero, clamp, negate
    always_comb begin
        pid_sum = SUM_W'(b_prod_p_reg) + SUM_W'(b_prod_i_reg) + SUM_W'(b_prod_d_reg);
        if (pid_sum < 0) begin
            pid_trunc = (pid_sum + SUM_W'((1 << GAIN_FRACTION_BITS) - 1))
                        >>> GAIN_FRACTION_BITS;
        end else begin
            pid_trunc = pid_sum >>> GAIN_FRACTION_BITS;
        end
        lim_pos = $signed({{(SUM_W-LIM_W){1'b0}}, corr_lim_reg});
        if (pid_trunc > lim_pos) begin
            c_corr_next = -$signed({1'b0, corr_lim_reg});
        end else if (pid_trunc < -lim_pos) begin
            c_corr_next = $signed({1'b0, corr_lim_reg});
        end else begin
            c_corr_next = -pid_trunc[CORR_W-1:0];
        end
    end

    // Output stage: sector mixing, wheel clamps, steer angles
    logic signed [WHEEL_W-1:0]  w_plus, w_minus, w_flat, w_front, w_right, w_left;
    logic signed [STEER_W-1:0]  steer_base;

    always_comb begin
        w_flat  = $signed({{(WHEEL_W-SPD_W){1'b0}}, c_speed_reg});
        w_plus  = w_flat + WHEEL_W'(c_corr_reg);
        w_minus = w_flat - WHEEL_W'(c_corr_reg);
        unique case (c_sec_reg)
            SEC_AHEAD: begin
                w_front = w_flat;  w_right = w_minus; w_left = w_plus;
            end
            SEC_RIGHT: begin
                w_front = w_plus;  w_right = w_minus; w_left = w_minus;
            end
            SEC_BACK: begin
                w_front = w_flat;  w_right = w_plus;  w_left = w_minus;
            end
            default: begin
                w_front = w_minus; w_right = w_plus;  w_left = w_plus;
            end
        endcase
        steer_base = STEER_W'(c_dir_reg) - STEER_W'(c_err_reg);
        out_data_next = '0;
        out_data_next[SPD_W-1:0]       = clamp_wheel(w_front, speed_max_reg, speed_min_reg);
        out_data_next[2*SPD_W-1:SPD_W] = clamp_wheel(w_right, speed_max_reg, speed_min_reg);
        out_data_next[3*SPD_W-1:2*SPD_W] = clamp_wheel(w_left, speed_max_reg, speed_min_reg);
        out_data_next[3*SPD_W+STEER_W-1:3*SPD_W] = steer_base;
        out_data_next[3*SPD_W+2*STEER_W-1:3*SPD_W+STEER_W] =
            steer_base - STEER_W'(STEER_OFFSET);
        out_data_next[3*SPD_W+3*STEER_W-1:3*SPD_W+2*STEER_W] =
            steer_base + STEER_W'(STEER_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage A
            a_speed_reg  <= ramp_speed_next;
            a_err_reg    <= err_now;
            a_integ_reg  <= integ_next;
            a_drv_reg    <= drv_now;
            a_dir_reg    <= in_dir;
            a_sec_reg    <= sec_now;
            // stage B: gain products
            b_prod_p_reg <= $signed({1'b0, gain_p_reg}) * a_err_reg;
            b_prod_i_reg <= $signed({1'b0, gain_i_reg}) * a_integ_reg;
            b_prod_d_reg <= $signed({1'b0, gain_d_reg}) * a_drv_reg;
            b_speed_reg  <= a_speed_reg;
            b_err_reg    <= a_err_reg;
            b_dir_reg    <= a_dir_reg;
            b_sec_reg    <= a_sec_reg;
            // stage C: correction
            c_corr_reg   <= c_corr_next;
            c_speed_reg  <= b_speed_reg;
            c_err_reg    <= b_err_reg;
            c_dir_reg    <= b_dir_reg;
            c_sec_reg    <= b_sec_reg;
            // result
            out_data_reg <= out_data_next;
        end
    end

    // ---------------- Assertions ----------------
    // The reference is always latched by the first request after reset
    a_stale_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !ref_stale_reg)
        else $error("reference still stale after a request");

    // Loop state only moves on an accepted request
    a_integ_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(integ_reg) && $stable(ramp_speed_reg) && $stable(ramp_cnt_reg))
        else $error("loop state changed without a request");

    // Correction stays within the configured limit
    a_corr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (c_corr_reg <= $signed({1'b0, corr_lim_reg}))
                     && (c_corr_reg >= -$signed({1'b0, corr_lim_reg})))
        else $error("correction outside limit");

    // Front wheel speed is one of the bounds or strictly between them
    a_wheel_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[SPD_W-1:0] == speed_max_reg)
                       || (out_data_reg[SPD_W-1:0] == speed_min_reg)
                       || ((out_data_reg[SPD_W-1:0] > speed_min_reg)
                           && (out_data_reg[SPD_W-1:0] < speed_max_reg)))
        else $error("front wheel speed outside clamp");

endmodule
